// ===== hdl/cidacc_pkg.sv =====
// Shared constants, codes and helper functions of the card-ID access controller.
package cidacc_pkg;

	localparam int MAX_IDS     = 5;
	localparam int ID_CHARS    = 10;
	localparam int TIMER_WIDTH = 16;

	localparam int IDX_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
	localparam int CNT_W = $clog2(MAX_IDS + 1);
	localparam int CH_W  = (ID_CHARS > 1) ? $clog2(ID_CHARS) : 1;
	localparam int LEN_W = $clog2(ID_CHARS + 1);
	localparam int TBL_DEPTH = MAX_IDS * ID_CHARS;
	localparam int TA_W  = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
	localparam int N_DEF = (MAX_IDS < 2) ? MAX_IDS : 2;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;

	typedef enum logic [2:0] {
		M_IDLE = 3'd0,
		M_WAIT = 3'd1,
		M_NEW  = 3'd2,
		M_SESS = 3'd3,
		M_FAIL = 3'd4,
		M_OK   = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		OP_CHAR   = 2'd0,
		OP_BUTTON = 2'd1,
		OP_TICK   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_VALID    = 3'd1;
	localparam logic [2:0] EV_INVALID  = 3'd2;
	localparam logic [2:0] EV_ENROLLED = 3'd3;
	localparam logic [2:0] EV_EXISTS   = 3'd4;
	localparam logic [2:0] EV_BAD_LEN  = 3'd5;
	localparam logic [2:0] EV_FULL     = 3'd6;
	localparam logic [2:0] EV_LOCKED   = 3'd7;

	localparam logic [2:0] DISP_IDLE     = 3'd0;
	localparam logic [2:0] DISP_VALID    = 3'd1;
	localparam logic [2:0] DISP_INSERT   = 3'd2;
	localparam logic [2:0] DISP_ENROLLED = 3'd4;
	localparam logic [2:0] DISP_EXISTS   = 3'd5;
	localparam logic [2:0] DISP_ERROR    = 3'd6;

	localparam logic [1:0] REG_WAIT_TICKS     = 2'd0;
	localparam logic [1:0] REG_SESSION_TICKS  = 2'd1;
	localparam logic [1:0] REG_ANNOUNCE_TICKS = 2'd2;

	// Default IDs, zero padded to the widest ID length.
	localparam logic [7:0] DEF_IDS [2][16] = '{
		'{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h61, 8'h64, 8'h6d, 8'h69, 8'h6e,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	function automatic logic [7:0] def_char(input logic [IDX_W-1:0] e,
			input logic [CH_W-1:0] c);
		return DEF_IDS[e[0]][4'(c)];
	endfunction

	// Table RAM address of character c of entry e.
	function automatic logic [TA_W-1:0] tbl_addr(input logic [IDX_W-1:0] e,
			input logic [CH_W-1:0] c);
		return TA_W'(32'(e) * ID_CHARS) + TA_W'(c);
	endfunction

endpackage

// ===== hdl/cidacc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module cidacc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/card_id_access_and_enroll_fsm_top.sv =====
// Card-ID access controller: sequencer, ID buffer and ID table RAMs, configuration port.
// A request that needs no table search goes through the execute and done states.
// A completed ID in card-wait or an enroll press walks the ID table RAM one character per
// cycle, and a newly enrolled ID is then copied from the ID buffer into the table.
// Throughput: one request at a time; the next is accepted the cycle after the result is loaded.
// Reset: an init pass writes the two default IDs into the table; requests stall meanwhile.
module card_id_access_and_enroll_fsm_top
	import cidacc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  rx_char,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  mode,
	output logic [2:0]  disp_msg,
	output logic        display_update,
	output logic        reader_select,
	output logic        admin_session,
	output logic [2:0]  event_res,
	output logic        echo_valid,
	output logic [7:0]  echo_char,
	output logic [2:0]  stored_ids,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_COPY,
		S_FIN,
		S_DONE
	} seq_t;

	seq_t st_q;

	// Configuration registers.
	logic [15:0] wait_ticks_q, sess_ticks_q, ann_ticks_q;

	// Architectural state.
	mode_t                  mode_q;
	logic                   admin_q, cap_q, trun_q;
	logic [LEN_W-1:0]       len_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [TIMER_WIDTH-1:0] tmr_q;
	logic [2:0]             disp_q;

	// Per-request result.
	logic [2:0] ev_q;
	logic       upd_q, echo_v_q;
	logic [7:0] echo_c_q;

	// Latched request.
	op_t        op_q;
	logic [7:0] char_q;

	// Table walk.
	logic [IDX_W-1:0] si_q, si_s1;
	logic [CH_W-1:0]  sj_q, sj_s1;
	logic             iss_done_q, rv_s1, mis_q, found_q, hit0_q;

	// Output register.
	logic       out_valid_q;
	mode_t      out_mode_q;
	logic [2:0] out_disp_q, out_ev_q, out_ids_q;
	logic       out_upd_q, out_admin_q, out_echo_v_q;
	logic [7:0] out_echo_c_q;

	// RAM ports.
	logic             buf_we;
	logic [CH_W-1:0]  buf_waddr;
	logic [7:0]       buf_rdata;
	logic             tbl_we;
	logic [TA_W-1:0]  tbl_waddr, tbl_raddr;
	logic [7:0]       tbl_wdata, tbl_rdata;

	logic             cfg_wr, cap_mode, cap_wr, issue_on, last_char_iss, last_ent_iss;
	logic             cmp_eq, cmp_mis;
	logic [LEN_W-1:0] len_inc;

	assign cfg_wr   = psel && penable && pwrite;
	assign pready   = 1'b1;
	assign cap_mode = (mode_q == M_WAIT) || (mode_q == M_NEW);
	assign cap_wr   = (st_q == S_EXEC) && (op_q == OP_CHAR) && cap_mode
		&& (char_q != CHAR_DOLLAR) && cap_q && (len_q < LEN_W'(ID_CHARS));
	assign len_inc  = len_q + LEN_W'(1);

	assign issue_on      = ((st_q == S_SCAN) || (st_q == S_COPY)) && !iss_done_q;
	assign last_char_iss = (sj_q == CH_W'(ID_CHARS - 1));
	assign last_ent_iss  = (CNT_W'(si_q) == cnt_q - CNT_W'(1));
	assign cmp_eq        = (tbl_rdata == buf_rdata);
	assign cmp_mis       = mis_q || !cmp_eq;

	assign buf_we    = cap_wr;
	assign buf_waddr = len_q[CH_W-1:0];
	assign tbl_raddr = tbl_addr(si_q, sj_q);

	always_comb begin
		if (st_q == S_INIT) begin
			tbl_we    = 1'b1;
			tbl_waddr = tbl_addr(si_q, sj_q);
			tbl_wdata = def_char(si_q, sj_q);
		end else begin
			tbl_we    = (st_q == S_COPY) && rv_s1;
			tbl_waddr = tbl_addr(IDX_W'(cnt_q), sj_s1);
			tbl_wdata = buf_rdata;
		end
	end

	cidacc_ram #(.WIDTH(8), .DEPTH(ID_CHARS)) u_buf_ram (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (char_q),
		.raddr (sj_q),
		.rdata (buf_rdata)
	);

	cidacc_ram #(.WIDTH(8), .DEPTH(TBL_DEPTH)) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	always_comb begin
		unique case (paddr[3:2])
			REG_WAIT_TICKS:     prdata = {16'd0, wait_ticks_q};
			REG_SESSION_TICKS:  prdata = {16'd0, sess_ticks_q};
			REG_ANNOUNCE_TICKS: prdata = {16'd0, ann_ticks_q};
			default:            prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_ticks_q <= 16'd1000;
			sess_ticks_q <= 16'd3000;
			ann_ticks_q  <= 16'd2000;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_WAIT_TICKS:     wait_ticks_q <= pwdata[15:0];
				REG_SESSION_TICKS:  sess_ticks_q <= pwdata[15:0];
				REG_ANNOUNCE_TICKS: ann_ticks_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read stage of the table walk: issue pointers are registered to line up with the registered RAM read at the compare.
	always_ff @(posedge clk) begin
		si_s1 <= si_q;
		sj_s1 <= sj_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_INIT;
			mode_q      <= M_IDLE;
			admin_q     <= 1'b0;
			cap_q       <= 1'b0;
			trun_q      <= 1'b0;
			len_q       <= '0;
			cnt_q       <= CNT_W'(N_DEF);
			tmr_q       <= '0;
			disp_q      <= DISP_IDLE;
			ev_q        <= EV_NONE;
			upd_q       <= 1'b0;
			echo_v_q    <= 1'b0;
			echo_c_q    <= 8'd0;
			op_q        <= OP_NONE;
			char_q      <= 8'd0;
			si_q        <= '0;
			sj_q        <= '0;
			iss_done_q  <= 1'b0;
			rv_s1       <= 1'b0;
			mis_q       <= 1'b0;
			found_q     <= 1'b0;
			hit0_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rv_s1 <= issue_on;
			if (out_valid_q && !res_stall && (st_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			if (issue_on) begin
				if (last_char_iss) begin
					sj_q <= '0;
					if ((st_q == S_COPY) || last_ent_iss) begin
						iss_done_q <= 1'b1;
					end else begin
						si_q <= si_q + IDX_W'(1);
					end
				end else begin
					sj_q <= sj_q + CH_W'(1);
				end
			end

			unique case (st_q)
				S_INIT: begin
					if (last_char_iss) begin
						sj_q <= '0;
						if (32'(si_q) == N_DEF - 1) begin
							st_q <= S_IDLE;
						end else begin
							si_q <= si_q + IDX_W'(1);
						end
					end else begin
						sj_q <= sj_q + CH_W'(1);
					end
				end

				S_IDLE: begin
					if (req_valid) begin
						op_q   <= op_t'(operation);
						char_q <= rx_char;
						st_q   <= S_EXEC;
					end
				end

				S_EXEC: begin
					ev_q       <= EV_NONE;
					upd_q      <= 1'b0;
					echo_v_q   <= 1'b0;
					echo_c_q   <= 8'd0;
					st_q       <= S_DONE;
					si_q       <= '0;
					sj_q       <= '0;
					iss_done_q <= 1'b0;
					mis_q      <= 1'b0;
					found_q    <= 1'b0;
					hit0_q     <= 1'b0;
					unique case (op_q)
						OP_CHAR: begin
							if (cap_mode) begin
								if (char_q == CHAR_DOLLAR) begin
									len_q    <= '0;
									cap_q    <= 1'b1;
									echo_v_q <= 1'b1;
									echo_c_q <= char_q;
									if (mode_q == M_WAIT) begin
										trun_q <= 1'b0;
									end
								end else if (cap_q) begin
									if (cap_wr) begin
										echo_v_q <= 1'b1;
										echo_c_q <= char_q;
										len_q    <= len_inc;
									end
									// A full ID in card-wait goes to the table lookup.
									if ((mode_q == M_WAIT)
										&& ((cap_wr ? len_inc : len_q)
										== LEN_W'(ID_CHARS))) begin
										cap_q <= 1'b0;
										st_q  <= (cnt_q == '0) ? S_FIN : S_SCAN;
									end
								end
							end
						end

						OP_BUTTON: begin
							if (mode_q == M_IDLE) begin
								mode_q <= M_WAIT;
								tmr_q  <= TIMER_WIDTH'(wait_ticks_q);
								trun_q <= 1'b1;
							end else if ((mode_q == M_SESS) && admin_q) begin
								trun_q <= 1'b0;
								mode_q <= M_NEW;
								disp_q <= DISP_INSERT;
								upd_q  <= 1'b1;
							end else if (mode_q == M_NEW) begin
								if (len_q == '0) begin
									cap_q   <= 1'b0;
									admin_q <= 1'b0;
									mode_q  <= M_IDLE;
									trun_q  <= 1'b0;
									ev_q    <= EV_LOCKED;
									disp_q  <= DISP_IDLE;
									upd_q   <= 1'b1;
								end else if (len_q == LEN_W'(ID_CHARS)) begin
									st_q <= (cnt_q == '0) ? S_FIN : S_SCAN;
								end else begin
									mode_q <= M_FAIL;
									disp_q <= DISP_ERROR;
									upd_q  <= 1'b1;
									ev_q   <= EV_BAD_LEN;
									tmr_q  <= TIMER_WIDTH'(ann_ticks_q);
									trun_q <= 1'b1;
								end
							end else if (mode_q != M_FAIL) begin
								cap_q   <= 1'b0;
								admin_q <= 1'b0;
								mode_q  <= M_IDLE;
								trun_q  <= 1'b0;
								ev_q    <= EV_LOCKED;
								disp_q  <= DISP_IDLE;
								upd_q   <= 1'b1;
							end
						end

						OP_TICK: begin
							if (trun_q) begin
								if (tmr_q > TIMER_WIDTH'(1)) begin
									tmr_q <= tmr_q - TIMER_WIDTH'(1);
								end else begin
									tmr_q  <= '0;
									trun_q <= 1'b0;
									case (mode_q) inside
										M_WAIT, M_SESS, M_OK: begin
											cap_q   <= 1'b0;
											admin_q <= 1'b0;
											mode_q  <= M_IDLE;
											ev_q    <= EV_LOCKED;
											// A card-wait timeout leaves the display alone.
											if (mode_q != M_WAIT) begin
												disp_q <= DISP_IDLE;
												upd_q  <= 1'b1;
											end
										end
										M_FAIL: begin
											len_q  <= '0;
											disp_q <= DISP_INSERT;
											upd_q  <= 1'b1;
											cap_q  <= 1'b0;
											mode_q <= M_NEW;
										end
										default: ;
									endcase
								end
							end
						end

						default: ;
					endcase
				end

				S_SCAN: begin
					if (rv_s1) begin
						if (sj_s1 == CH_W'(ID_CHARS - 1)) begin
							mis_q <= 1'b0;
							if (!cmp_mis) begin
								found_q <= 1'b1;
								hit0_q  <= (si_s1 == '0);
								st_q    <= S_FIN;
							end else if (CNT_W'(si_s1) == cnt_q - CNT_W'(1)) begin
								st_q <= S_FIN;
							end
						end else begin
							mis_q <= cmp_mis;
						end
					end
				end

				S_FIN: begin
					st_q <= S_DONE;
					if (mode_q == M_WAIT) begin
						if (found_q) begin
							disp_q <= DISP_VALID;
							upd_q  <= 1'b1;
							if (hit0_q) begin
								admin_q <= 1'b1;
							end
							tmr_q  <= TIMER_WIDTH'(sess_ticks_q);
							trun_q <= 1'b1;
							mode_q <= M_SESS;
							ev_q   <= EV_VALID;
						end else begin
							ev_q <= EV_INVALID;
						end
					end else begin
						tmr_q  <= TIMER_WIDTH'(ann_ticks_q);
						trun_q <= 1'b1;
						if (found_q) begin
							mode_q <= M_FAIL;
							disp_q <= DISP_EXISTS;
							upd_q  <= 1'b1;
							ev_q   <= EV_EXISTS;
						end else if (cnt_q >= CNT_W'(MAX_IDS)) begin
							mode_q <= M_FAIL;
							disp_q <= DISP_ERROR;
							upd_q  <= 1'b1;
							ev_q   <= EV_FULL;
						end else begin
							si_q       <= '0;
							sj_q       <= '0;
							iss_done_q <= 1'b0;
							st_q       <= S_COPY;
						end
					end
				end

				S_COPY: begin
					if (rv_s1 && (sj_s1 == CH_W'(ID_CHARS - 1))) begin
						cnt_q  <= cnt_q + CNT_W'(1);
						mode_q <= M_OK;
						disp_q <= DISP_ENROLLED;
						upd_q  <= 1'b1;
						ev_q   <= EV_ENROLLED;
						st_q   <= S_DONE;
					end
				end

				S_DONE: begin
					if (!out_valid_q || !res_stall) begin
						out_valid_q <= 1'b1;
						st_q        <= S_IDLE;
					end
				end

				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == S_DONE) && (!out_valid_q || !res_stall)) begin
			out_mode_q   <= mode_q;
			out_disp_q   <= disp_q;
			out_upd_q    <= upd_q;
			out_admin_q  <= admin_q;
			out_ev_q     <= ev_q;
			out_echo_v_q <= echo_v_q;
			out_echo_c_q <= echo_c_q;
			out_ids_q    <= 3'(cnt_q);
		end
	end

	assign req_stall      = (st_q != S_IDLE);
	assign res_valid      = out_valid_q;
	assign mode           = out_mode_q;
	assign disp_msg       = out_disp_q;
	assign display_update = out_upd_q;
	assign reader_select  = (out_mode_q != M_IDLE);
	assign admin_session  = out_admin_q;
	assign event_res      = out_ev_q;
	assign echo_valid     = out_echo_v_q;
	assign echo_char      = out_echo_c_q;
	assign stored_ids     = out_ids_q;

`ifndef ASSERT_OFF
	a_admin_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		admin_q |-> (mode_q != M_IDLE))
		else $error("admin session open while idle");

	// The announce timer starts before the new ID is copied, while the mode is still new-card.
	a_timer_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(trun_q && (st_q != S_COPY)) |-> ((mode_q != M_IDLE) && (mode_q != M_NEW)))
		else $error("timer running in idle or new-card mode");

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CNT_W'(MAX_IDS)) && (len_q <= LEN_W'(ID_CHARS)))
		else $error("ID count or ID length out of range");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SCAN) |-> !tbl_we)
		else $error("table written during lookup");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (st_q == S_EXEC))
		else $error("accepted request not executed");
`endif

endmodule

// ===== tb/card_id_access_and_enroll_fsm_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the card-ID access controller with an in-order result predictor.
module card_id_access_and_enroll_fsm_top_tb;
	import cidacc_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		logic [2:0] mode;
		logic [2:0] disp;
		logic       upd;
		logic       rsel;
		logic       admin;
		logic [2:0] ev;
		logic       echo_v;
		logic [7:0] echo_c;
		logic [2:0] ids;
	} access_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  operation = OP_NONE;
	logic [7:0]  rx_char = 8'h00;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [2:0]  mode;
	logic [2:0]  disp_msg;
	logic        display_update;
	logic        reader_select;
	logic        admin_session;
	logic [2:0]  event_res;
	logic        echo_valid;
	logic [7:0]  echo_char;
	logic [2:0]  stored_ids;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	card_id_access_and_enroll_fsm_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.operation(operation), .rx_char(rx_char),
		.res_valid(res_valid), .res_stall(res_stall),
		.mode(mode), .disp_msg(disp_msg), .display_update(display_update),
		.reader_select(reader_select), .admin_session(admin_session),
		.event_res(event_res), .echo_valid(echo_valid), .echo_char(echo_char),
		.stored_ids(stored_ids),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted controller state.
	mode_t       fsm_mode;
	logic        admin_on;
	logic        capturing;
	logic [7:0]  id_buf [ID_CHARS];
	int          id_len;
	logic [7:0]  id_tab [MAX_IDS][ID_CHARS];
	int          id_cnt;
	int          tmr_left;
	logic        tmr_on;
	logic [2:0]  disp_reg;
	logic [15:0] wait_ticks_cfg;
	logic [15:0] session_ticks_cfg;
	logic [15:0] announce_ticks_cfg;

	// Side outputs of the request being predicted.
	logic [2:0]  cur_ev;
	logic        cur_upd;
	logic        cur_echo_v;
	logic [7:0]  cur_echo_c;

	access_result_t pending_results[$];
	logic [7:0]     card_plan[$];
	access_result_t seen_res;
	access_result_t want_res;
	int mismatch_cnt = 0;
	int sent_reqs = 0;
	int cycle_cnt = 0;
	int burst_left = 0;
	bit tx_steady = 1'b0;
	bit rx_quiet = 1'b0;
	int hold_req = 0;
	int hold_left = 0;
	int run_left = 0;
	bit stall_phase = 1'b0;

	function automatic void init_access_model();
		string adm;
		string usr;
		adm = "12345admin";
		usr = "12345aaaaa";
		fsm_mode = M_IDLE;
		admin_on = 1'b0;
		capturing = 1'b0;
		id_len = 0;
		tmr_left = 0;
		tmr_on = 1'b0;
		disp_reg = DISP_IDLE;
		wait_ticks_cfg = 16'd1000;
		session_ticks_cfg = 16'd3000;
		announce_ticks_cfg = 16'd2000;
		for (int j = 0; j < ID_CHARS; j++) begin
			id_buf[j] = 8'h00;
			for (int i = 0; i < MAX_IDS; i++)
				id_tab[i][j] = 8'h00;
			id_tab[0][j] = (j < adm.len()) ? adm[j] : 8'h00;
			id_tab[1][j] = (j < usr.len()) ? usr[j] : 8'h00;
		end
		id_cnt = 2;
	endfunction

	function automatic void show_msg(logic [2:0] code);
		disp_reg = code;
		cur_upd = 1'b1;
	endfunction

	function automatic void lock_fsm();
		capturing = 1'b0;
		admin_on = 1'b0;
		fsm_mode = M_IDLE;
		tmr_on = 1'b0;
		cur_ev = EV_LOCKED;
	endfunction

	function automatic void arm_timer(logic [15:0] ticks);
		tmr_left = int'(ticks);
		tmr_on = 1'b1;
	endfunction

	function automatic int find_entry();
		bit same;
		for (int i = 0; i < id_cnt; i++) begin
			same = 1'b1;
			for (int j = 0; j < ID_CHARS; j++)
				if (id_tab[i][j] !== id_buf[j])
					same = 1'b0;
			if (same)
				return i;
		end
		return -1;
	endfunction

	function automatic access_result_t step_access_fsm(op_t op, logic [7:0] ch);
		int k;
		access_result_t r;
		cur_ev = EV_NONE;
		cur_upd = 1'b0;
		cur_echo_v = 1'b0;
		cur_echo_c = 8'h00;
		case (op)
		OP_CHAR: begin
			if (fsm_mode == M_WAIT || fsm_mode == M_NEW) begin
				if (ch == CHAR_DOLLAR) begin
					id_len = 0;
					capturing = 1'b1;
					if (fsm_mode == M_WAIT)
						tmr_on = 1'b0;
					cur_echo_v = 1'b1;
					cur_echo_c = ch;
				end else if (capturing) begin
					// Once the buffer is full, further characters are dropped silently.
					if (id_len < ID_CHARS) begin
						cur_echo_v = 1'b1;
						cur_echo_c = ch;
						id_buf[id_len] = ch;
						id_len++;
					end
					if (fsm_mode == M_WAIT && id_len == ID_CHARS) begin
						k = find_entry();
						if (k >= 0) begin
							show_msg(DISP_VALID);
							if (k == 0)
								admin_on = 1'b1;
							arm_timer(session_ticks_cfg);
							fsm_mode = M_SESS;
							cur_ev = EV_VALID;
						end else begin
							cur_ev = EV_INVALID;
						end
						capturing = 1'b0;
					end
				end
			end
		end
		OP_BUTTON: begin
			if (fsm_mode == M_IDLE) begin
				fsm_mode = M_WAIT;
				arm_timer(wait_ticks_cfg);
			end else if (fsm_mode == M_SESS && admin_on) begin
				tmr_on = 1'b0;
				fsm_mode = M_NEW;
				show_msg(DISP_INSERT);
			end else if (fsm_mode == M_NEW) begin
				if (id_len == 0) begin
					lock_fsm();
					show_msg(DISP_IDLE);
				end else if (id_len == ID_CHARS) begin
					if (find_entry() >= 0) begin
						fsm_mode = M_FAIL;
						show_msg(DISP_EXISTS);
						cur_ev = EV_EXISTS;
					end else if (id_cnt >= MAX_IDS) begin
						fsm_mode = M_FAIL;
						show_msg(DISP_ERROR);
						cur_ev = EV_FULL;
					end else begin
						for (int j = 0; j < ID_CHARS; j++)
							id_tab[id_cnt][j] = id_buf[j];
						id_cnt++;
						fsm_mode = M_OK;
						show_msg(DISP_ENROLLED);
						cur_ev = EV_ENROLLED;
					end
					arm_timer(announce_ticks_cfg);
				end else begin
					fsm_mode = M_FAIL;
					show_msg(DISP_ERROR);
					cur_ev = EV_BAD_LEN;
					arm_timer(announce_ticks_cfg);
				end
			end else if (fsm_mode != M_FAIL) begin
				lock_fsm();
				show_msg(DISP_IDLE);
			end
		end
		OP_TICK: begin
			if (tmr_on) begin
				if (tmr_left > 1) begin
					tmr_left--;
				end else begin
					tmr_left = 0;
					tmr_on = 1'b0;
					case (fsm_mode)
					M_WAIT: lock_fsm();
					M_SESS, M_OK: begin
						show_msg(DISP_IDLE);
						lock_fsm();
					end
					M_FAIL: begin
						id_len = 0;
						show_msg(DISP_INSERT);
						capturing = 1'b0;
						fsm_mode = M_NEW;
					end
					default: ;
					endcase
				end
			end
		end
		default: ;
		endcase
		r.mode = fsm_mode;
		r.disp = disp_reg;
		r.upd = cur_upd;
		r.rsel = (fsm_mode != M_IDLE);
		r.admin = admin_on;
		r.ev = cur_ev;
		r.echo_v = cur_echo_v;
		r.echo_c = cur_echo_c;
		r.ids = 3'(id_cnt);
		return r;
	endfunction

	function automatic string show_res(access_result_t r);
		return $sformatf("mode=%0d disp=%0d upd=%0b sel=%0b admin=%0b ev=%0d echo=%0b/%02h ids=%0d",
			r.mode, r.disp, r.upd, r.rsel, r.admin, r.ev, r.echo_v, r.echo_c, r.ids);
	endfunction

	function automatic void flag_mismatch(string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	function automatic logic [7:0] id_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c == CHAR_DOLLAR)
			c = ~c;
		return c;
	endfunction

	// Chooses the characters that follow a '$': a stored ID, a random one, or, in new-card mode, a bad length.
	function automatic void plan_card_id();
		int r;
		int n;
		int e;
		r = $urandom_range(0, 99);
		card_plan.delete();
		e = -1;
		n = ID_CHARS;
		if (fsm_mode == M_WAIT) begin
			if (r < 45)
				e = 0;
			else if (r < 75)
				e = $urandom_range(0, id_cnt - 1);
		end else begin
			if (r < 20)
				e = $urandom_range(0, id_cnt - 1);
			else if (r < 45)
				n = $urandom_range(1, ID_CHARS - 1);
			else if (r < 65)
				n = $urandom_range(ID_CHARS + 1, ID_CHARS + 4);
		end
		for (int i = 0; i < n; i++)
			card_plan.push_back(e >= 0 ? id_tab[e][i] : id_char());
	endfunction

	task automatic issue_request(op_t op, logic [7:0] ch);
		access_result_t r;
		int gap;
		@(negedge clk);
		if (!tx_steady && burst_left == 0) begin
			req_valid = 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0)
			burst_left--;
		req_valid = 1'b1;
		operation = op;
		rx_char = ch;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		r = step_access_fsm(op, ch);
		pending_results.push_back(r);
		sent_reqs++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_timer_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = 32'(val);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== 32'(val))
			flag_mismatch($sformatf("register %0d read back: exp %0d got %0d", idx, val, prdata));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		case (idx)
		REG_WAIT_TICKS:     wait_ticks_cfg = val;
		REG_SESSION_TICKS:  session_ticks_cfg = val;
		REG_ANNOUNCE_TICKS: announce_ticks_cfg = val;
		default: ;
		endcase
	endtask

	task automatic set_timers(logic [15:0] wait_t, logic [15:0] sess_t, logic [15:0] ann_t);
		drain_results();
		write_timer_reg(REG_WAIT_TICKS, wait_t);
		write_timer_reg(REG_SESSION_TICKS, sess_t);
		write_timer_reg(REG_ANNOUNCE_TICKS, ann_t);
	endtask

	// Picks the next request from the predicted state, so most requests follow a real session.
	task automatic random_step();
		int r;
		op_t op;
		logic [7:0] ch;
		r = $urandom_range(0, 99);
		ch = 8'($urandom_range(0, 255));
		op = OP_TICK;
		if (fsm_mode != M_WAIT && fsm_mode != M_NEW)
			card_plan.delete();
		if (r < 6) begin
			op = op_t'($urandom_range(0, 3));
		end else begin
			case (fsm_mode)
			M_IDLE: op = (r < 85) ? OP_BUTTON : (r < 93) ? OP_TICK : OP_CHAR;
			M_WAIT, M_NEW: begin
				if (card_plan.size() != 0) begin
					if (r < 90) begin
						op = OP_CHAR;
						ch = card_plan.pop_front();
					end
				end else if (fsm_mode == M_NEW && capturing) begin
					if (r < 85)
						op = OP_BUTTON;
				end else if (r < 75) begin
					op = OP_CHAR;
					ch = CHAR_DOLLAR;
					plan_card_id();
				end else if (r >= 88) begin
					op = OP_BUTTON;
				end
			end
			M_SESS: if (admin_on ? r < 70 : r >= 75) op = OP_BUTTON;
			default: if (r >= 85) op = OP_BUTTON;
			endcase
		end
		issue_request(op, ch);
	endtask

	task automatic run_random(int n);
		int start;
		start = sent_reqs;
		while (sent_reqs - start < n)
			random_step();
	endtask

	task automatic test_reg_access();
		set_timers(16'hFFFF, 16'hFFFF, 16'hFFFF);
		set_timers(16'd1, 16'd1, 16'd1);
	endtask

	task automatic test_directed_walk();
		string adm;
		adm = "12345admin";
		// A zero wait time expires on the first tick.
		set_timers(16'd0, 16'd2, 16'd1);
		issue_request(OP_NONE, 8'hFF);
		issue_request(OP_TICK, 8'h00);
		issue_request(OP_CHAR, "x");
		issue_request(OP_BUTTON, 8'h00);
		issue_request(OP_TICK, 8'h00);
		issue_request(OP_BUTTON, 8'h00);
		issue_request(OP_CHAR, "A");
		issue_request(OP_CHAR, CHAR_DOLLAR);
		for (int i = 0; i < adm.len(); i++)
			issue_request(OP_CHAR, adm[i]);
		issue_request(OP_BUTTON, 8'h00);
		// The login ID is still in the buffer, so this enroll finds it already stored.
		issue_request(OP_BUTTON, 8'h00);
		issue_request(OP_BUTTON, 8'h00);
		issue_request(OP_TICK, 8'h00);
		issue_request(OP_BUTTON, 8'h00);
	endtask

	task automatic test_random_mixed();
		set_timers(16'd3, 16'd5, 16'd2);
		run_random(450);
	endtask

	task automatic test_random_no_idle();
		set_timers(16'd1, 16'd1, 16'd1);
		tx_steady = 1'b1;
		rx_quiet = 1'b1;
		run_random(350);
		drain_results();
		tx_steady = 1'b0;
		rx_quiet = 1'b0;
	endtask

	task automatic test_random_long_timers();
		set_timers(16'hFFFF, 16'hFFFF, 16'd2);
		run_random(300);
	endtask

	task automatic test_backpressure();
		set_timers(16'd4, 16'd6, 16'd3);
		hold_req = 400;
		tx_steady = 1'b1;
		run_random(40);
		tx_steady = 1'b0;
		drain_results();
		run_random(60);
	endtask

	task automatic test_random_varied();
		repeat (5) begin
			set_timers(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
				16'($urandom_range(1, 12)));
			run_random(130);
		end
	endtask

	// Receiver: alternating stall and pass runs, a long hold-off on request, or no stall while quiet.
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			res_stall = 1'b1;
			hold_left--;
		end else if (rx_quiet) begin
			res_stall = 1'b0;
		end else begin
			if (run_left == 0) begin
				stall_phase = !stall_phase;
				run_left = stall_phase ? $urandom_range(1, 5) : $urandom_range(1, 12);
			end
			res_stall = stall_phase;
			run_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			seen_res = {mode, disp_msg, display_update, reader_select, admin_session,
				event_res, echo_valid, echo_char, stored_ids};
			if (pending_results.size() == 0) begin
				flag_mismatch({"result with no request waiting: ", show_res(seen_res)});
			end else begin
				want_res = pending_results.pop_front();
				if (seen_res !== want_res)
					flag_mismatch({"exp ", show_res(want_res), " got ", show_res(seen_res)});
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		init_access_model();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reg_access();
		test_directed_walk();
		test_random_mixed();
		test_random_no_idle();
		test_random_long_timers();
		test_backpressure();
		test_random_varied();
		drain_results();
		repeat (80) @(posedge clk);
		if (mismatch_cnt == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/cidacc_pkg.sv
hdl/cidacc_ram.sv
hdl/card_id_access_and_enroll_fsm_top.sv
tb/card_id_access_and_enroll_fsm_top_tb.sv
